// ===== rtl/linear_interp_resampler_core_defines.svh =====
// Assertion macros shared by the resampler RTL.
`ifndef LINEAR_INTERP_RESAMPLER_CORE_DEFINES_SVH
`define LINEAR_INTERP_RESAMPLER_CORE_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define LIR_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define LIR_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/lir_pkg.sv =====
`default_nettype none

package lir_pkg;

    // Default widths
    localparam int SAMPLE_BITS_DEF = 24;
    localparam int FRAC_BITS_DEF   = 16;

    // Integer bits of the phase accumulator
    localparam int PHASE_INT_BITS = 4;

    // Most device-rate samples produced from one frame
    localparam int MAX_OUT = 16;

    // Control from the sequencer to the interpolation unit
    typedef struct packed {
        logic load;
        logic sel_right;
    } lir_ctl_t;

endpackage

`default_nettype wire

// ===== rtl/lir_lerp_unit.sv =====
`default_nettype none

// Shared interpolation unit: one channel per load, result in the cycle after the load.
module lir_lerp_unit
    import lir_pkg::*;
#(
    parameter int SAMPLE_BITS = SAMPLE_BITS_DEF,
    parameter int FRAC_BITS   = FRAC_BITS_DEF
) (
    input  wire logic                          aclk,
    input  wire lir_ctl_t                      ctl,
    input  wire logic signed [SAMPLE_BITS-1:0] a_left,
    input  wire logic signed [SAMPLE_BITS-1:0] b_left,
    input  wire logic signed [SAMPLE_BITS-1:0] a_right,
    input  wire logic signed [SAMPLE_BITS-1:0] b_right,
    input  wire logic        [FRAC_BITS-1:0]   phase_frac,
    output logic signed      [SAMPLE_BITS-1:0] result
);

    localparam int PROD_BITS = SAMPLE_BITS + FRAC_BITS + 2;

    logic signed [SAMPLE_BITS-1:0] a_sel;
    logic signed [SAMPLE_BITS-1:0] b_sel;
    logic signed [SAMPLE_BITS:0]   diff;
    logic signed [FRAC_BITS:0]     phase_s;
    logic signed [PROD_BITS-1:0]   prod_next;
    logic signed [PROD_BITS-1:0]   prod_reg;
    logic signed [SAMPLE_BITS-1:0] base_reg;
    logic signed [PROD_BITS-1:0]   prod_shift;
    logic signed [SAMPLE_BITS:0]   sum;

    // Pick the channel and form (b - a) * phase
    assign a_sel     = ctl.sel_right ? a_right : a_left;
    assign b_sel     = ctl.sel_right ? b_right : b_left;
    assign diff      = {b_sel[SAMPLE_BITS-1], b_sel} - {a_sel[SAMPLE_BITS-1], a_sel};
    assign phase_s   = $signed({1'b0, phase_frac});
    assign prod_next = PROD_BITS'(diff) * PROD_BITS'(phase_s);

    // Hold the product and its base sample
    always_ff @(posedge aclk) begin
        if (ctl.load) begin
            prod_reg <= prod_next;
            base_reg <= a_sel;
        end
    end

    // Floor the product and add the base sample
    assign prod_shift = prod_reg >>> FRAC_BITS;
    assign sum        = {base_reg[SAMPLE_BITS-1], base_reg} + prod_shift[SAMPLE_BITS:0];
    assign result     = sum[SAMPLE_BITS-1:0];

endmodule

`default_nettype wire

// ===== rtl/linear_interp_resampler_core.sv =====
// Stereo linear-interpolation rate converter with a phase accumulator.
// Input stream: s_tdata carries one native-rate frame (left, right), s_tuser
// is the restart flag that clears the phase and the kept frame, as after a seek.
// Output stream: m_tdata carries one device-rate frame, m_tlast marks the last
// output caused by the input frame. A frame whose phase starts at or above one
// produces no output; it moves the phase on and becomes the kept frame.
// Sequence: a frame is taken in ST_IDLE and checked in ST_CHECK, then each output
// passes through the shared multiplier in ST_MUL_L (left product), ST_MUL_R
// (right product) and ST_ADD_R (final add); s_tready stays low until the frame's
// last output is done. The ratio register (cfg_we, cfg_wdata) is to be written
// by the user only while the block is idle; the block does not enforce this.
// Reset (aresetn low, synchronous) clears the phase, the kept-frame flag and the
// output valid, and loads a ratio of one.
// Receiver stall: a finished output waits in the output register; the next
// frame may be taken meanwhile, and the sequencer holds before the next left
// product until the pending output has been transferred.
`default_nettype none

module linear_interp_resampler_core
    import lir_pkg::*;
#(
    parameter int SAMPLE_BITS = SAMPLE_BITS_DEF,
    parameter int FRAC_BITS   = FRAC_BITS_DEF,
    localparam int PHASE_BITS = FRAC_BITS + PHASE_INT_BITS,
    localparam int TDATA_BITS = ((2 * SAMPLE_BITS + 7) / 8) * 8
) (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    // ratio of native to device rate, FRAC_BITS fraction bits
    input  wire logic                  cfg_we,
    input  wire logic [PHASE_BITS-1:0] cfg_wdata,
    input  wire logic                  s_tvalid,
    output logic                       s_tready,
    input  wire logic [TDATA_BITS-1:0] s_tdata,  // sample_left, sample_right, zero pad
    input  wire logic                  s_tuser,  // restart
    output logic                       m_tvalid,
    input  wire logic                  m_tready,
    output logic [TDATA_BITS-1:0]      m_tdata,  // out_left, out_right, zero pad
    output logic                       m_tlast   // last_of_run
);

`include "linear_interp_resampler_core_defines.svh"

    localparam int CNT_BITS = $clog2(MAX_OUT);
    localparam logic [PHASE_BITS-1:0] ONE = PHASE_BITS'(1) << FRAC_BITS;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CHECK,
        ST_MUL_L,
        ST_MUL_R,
        ST_ADD_R
    } state_t;

    state_t                        state_reg,     state_next;
    logic [PHASE_BITS-1:0]         ratio_reg,     ratio_next;
    logic [PHASE_BITS-1:0]         phase_reg,     phase_next;
    logic [CNT_BITS-1:0]           count_reg,     count_next;
    logic                          have_prev_reg, have_prev_next;
    logic                          m_tvalid_reg,  m_tvalid_next;
    logic                          m_tlast_reg,   m_tlast_next;
    logic signed [SAMPLE_BITS-1:0] a_left_reg,    a_left_next;
    logic signed [SAMPLE_BITS-1:0] a_right_reg,   a_right_next;
    logic signed [SAMPLE_BITS-1:0] b_left_reg,    b_left_next;
    logic signed [SAMPLE_BITS-1:0] b_right_reg,   b_right_next;
    logic signed [SAMPLE_BITS-1:0] prev_left_reg, prev_left_next;
    logic signed [SAMPLE_BITS-1:0] prev_right_reg, prev_right_next;
    logic signed [SAMPLE_BITS-1:0] out_left_reg,  out_left_next;
    logic signed [SAMPLE_BITS-1:0] out_right_reg, out_right_next;

    logic                          s_xfer;
    logic                          out_busy;
    logic signed [SAMPLE_BITS-1:0] in_left;
    logic signed [SAMPLE_BITS-1:0] in_right;
    logic                          use_prev;
    logic [PHASE_BITS:0]           phase_sum;
    logic [PHASE_BITS-1:0]         phase_sat;
    logic                          run_last;
    logic signed [SAMPLE_BITS-1:0] lerp_result;
    lir_ctl_t                      unit_ctl;

    assign s_tready = (state_reg == ST_IDLE);
    assign s_xfer   = s_tvalid && s_tready;
    assign out_busy = m_tvalid_reg && !m_tready;
    assign in_left  = s_tdata[SAMPLE_BITS-1:0];
    assign in_right = s_tdata[2*SAMPLE_BITS-1:SAMPLE_BITS];
    assign use_prev = have_prev_reg && !s_tuser;

    // Advance the phase with saturation, and spot the last output of the run
    assign phase_sum = {1'b0, phase_reg} + {1'b0, ratio_reg};
    assign phase_sat = phase_sum[PHASE_BITS] ? '1 : phase_sum[PHASE_BITS-1:0];
    assign run_last  = (phase_sat >= ONE) || (count_reg == CNT_BITS'(MAX_OUT - 1));

    // Drive the shared unit: left in MUL_L, right in MUL_R
    always_comb begin
        unit_ctl.load      = ((state_reg == ST_MUL_L) && !out_busy) || (state_reg == ST_MUL_R);
        unit_ctl.sel_right = (state_reg == ST_MUL_R);
    end

    lir_lerp_unit #(
        .SAMPLE_BITS (SAMPLE_BITS),
        .FRAC_BITS   (FRAC_BITS)
    ) u_lerp (
        .aclk       (aclk),
        .ctl        (unit_ctl),
        .a_left     (a_left_reg),
        .b_left     (b_left_reg),
        .a_right    (a_right_reg),
        .b_right    (b_right_reg),
        .phase_frac (phase_reg[FRAC_BITS-1:0]),
        .result     (lerp_result)
    );

    // Sequencer
    always_comb begin
        state_next      = state_reg;
        ratio_next      = cfg_we ? cfg_wdata : ratio_reg;
        phase_next      = phase_reg;
        count_next      = count_reg;
        have_prev_next  = have_prev_reg;
        m_tvalid_next   = m_tvalid_reg && !m_tready;
        m_tlast_next    = m_tlast_reg;
        a_left_next     = a_left_reg;
        a_right_next    = a_right_reg;
        b_left_next     = b_left_reg;
        b_right_next    = b_right_reg;
        prev_left_next  = prev_left_reg;
        prev_right_next = prev_right_reg;
        out_left_next   = out_left_reg;
        out_right_next  = out_right_reg;

        case (state_reg)
            ST_IDLE: begin
                // Take the frame; a restart drops the phase and the kept frame
                if (s_xfer) begin
                    b_left_next  = in_left;
                    b_right_next = in_right;
                    a_left_next  = use_prev ? prev_left_reg : in_left;
                    a_right_next = use_prev ? prev_right_reg : in_right;
                    phase_next   = s_tuser ? '0 : phase_reg;
                    count_next   = '0;
                    state_next   = ST_CHECK;
                end
            end
            ST_CHECK: begin
                // No output when the phase is already at or above one
                if (phase_reg < ONE) begin
                    state_next = ST_MUL_L;
                end else begin
                    phase_next      = phase_reg - ONE;
                    prev_left_next  = b_left_reg;
                    prev_right_next = b_right_reg;
                    have_prev_next  = 1'b1;
                    state_next      = ST_IDLE;
                end
            end
            ST_MUL_L: begin
                // Hold until the pending output has been transferred
                if (!out_busy) begin
                    state_next = ST_MUL_R;
                end
            end
            ST_MUL_R: begin
                out_left_next = lerp_result;
                state_next    = ST_ADD_R;
            end
            ST_ADD_R: begin
                out_right_next = lerp_result;
                m_tvalid_next  = 1'b1;
                m_tlast_next   = run_last;
                if (run_last) begin
                    phase_next      = (phase_sat >= ONE) ? (phase_sat - ONE) : '0;
                    prev_left_next  = b_left_reg;
                    prev_right_next = b_right_reg;
                    have_prev_next  = 1'b1;
                    state_next      = ST_IDLE;
                end else begin
                    phase_next = phase_sat;
                    count_next = count_reg + CNT_BITS'(1);
                    state_next = ST_MUL_L;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Hold state and registered outputs
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            ratio_reg     <= ONE;
            phase_reg     <= '0;
            count_reg     <= '0;
            have_prev_reg <= 1'b0;
            m_tvalid_reg  <= 1'b0;
            m_tlast_reg   <= 1'b0;
        end else begin
            state_reg     <= state_next;
            ratio_reg     <= ratio_next;
            phase_reg     <= phase_next;
            count_reg     <= count_next;
            have_prev_reg <= have_prev_next;
            m_tvalid_reg  <= m_tvalid_next;
            m_tlast_reg   <= m_tlast_next;
        end
        a_left_reg     <= a_left_next;
        a_right_reg    <= a_right_next;
        b_left_reg     <= b_left_next;
        b_right_reg    <= b_right_next;
        prev_left_reg  <= prev_left_next;
        prev_right_reg <= prev_right_next;
        out_left_reg   <= out_left_next;
        out_right_reg  <= out_right_next;
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tlast  = m_tlast_reg;
    assign m_tdata  = TDATA_BITS'({out_right_reg, out_left_reg});

    // Checks on the sequencer
    `LIR_ASSERT_NXT(a_busy_after_take, aclk, aresetn, s_xfer, !s_tready, "frame taken while busy")
    `LIR_ASSERT_IMP(a_phase_in_range, aclk, aresetn, state_reg == ST_MUL_L, phase_reg < ONE, "interpolating at phase >= one")
    `LIR_ASSERT_IMP(a_no_overwrite, aclk, aresetn, state_reg == ST_MUL_R, !m_tvalid_reg, "pending output about to be overwritten")

endmodule

`default_nettype wire
